// File: rtl/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg: shared types and constants for the cubic interpolating resampler
// Sample and phase formats, payload structs, register widths.
// ----------------------------------------------------------------------------
package cir_pkg;

	localparam int MAX_CHANNELS   = 8;
	localparam int HISTORY_FRAMES = 4;
	localparam int SAMPLE_BITS    = 24;
	localparam int FRAC_BITS      = 16;
	localparam int PHASE_BITS     = FRAC_BITS + 5;
	localparam int STEP_BITS      = 20;
	localparam int NCH_BITS       = 4;
	localparam int CHAN_BITS      = 3;
	localparam int MAX_RESULTS    = 64;
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 3;

	// Working width of the interpolation datapath (see bound notes in cir_interp)
	localparam int CALC_BITS = SAMPLE_BITS + 6;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CHAN_BITS-1:0]          channel;
	} src_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic [CHAN_BITS-1:0]          out_channel;
		logic                          last;
	} res_t;

endpackage

// File: rtl/cir_hist_mem.sv
// ----------------------------------------------------------------------------
// cir_hist_mem: sample history memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cir_hist_mem #(
	parameter int DEPTH = cir_pkg::MAX_CHANNELS * cir_pkg::HISTORY_FRAMES,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  cir_pkg::sample_t wdata,
	input  logic [AW-1:0]    raddr,
	output cir_pkg::sample_t rdata
);
	import cir_pkg::*;

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/cir_interp.sv
// ----------------------------------------------------------------------------
// cir_interp: Catmull-Rom evaluation unit
// Horner form over three rounds on one shared registered multiplier.
// ----------------------------------------------------------------------------
module cir_interp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  cir_pkg::sample_t                y0,
	input  cir_pkg::sample_t                y1,
	input  cir_pkg::sample_t                y2,
	input  cir_pkg::sample_t                y3,
	input  logic [cir_pkg::FRAC_BITS-1:0]   x,
	output logic                            done,
	output cir_pkg::sample_t                result
);
	import cir_pkg::*;

	localparam int W  = CALC_BITS;
	localparam int PW = W + FRAC_BITS + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [W-1:0] SMAX = {{(W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = ~SMAX;

	typedef enum logic [4:0] {
		IS_IDLE = 5'b00001,
		IS_COEF = 5'b00010,
		IS_MUL  = 5'b00100,
		IS_ADD  = 5'b01000,
		IS_DONE = 5'b10000
	} ist_t;

	ist_t state_q;
	logic [1:0] round_q;

	logic signed [W-1:0]  t_q, b_q, c_q, d_q;
	logic signed [PW-1:0] prod_q;

	logic signed [W-1:0]  e0, e1, e2, e3, d12;
	logic signed [W-1:0]  coef_a, coef_b, coef_c, coef_d;
	logic signed [PW-1:0] rsum;
	logic signed [W-1:0]  rnd, addend;
	logic signed [W-1:0]  tp1, halved;

	// |A| <= 8*2^(S-1), |B| <= 12*2^(S-1); every Horner term stays below 2^(S+4)
	always_comb begin
		e0     = W'(y0);
		e1     = W'(y1);
		e2     = W'(y2);
		e3     = W'(y3);
		d12    = e1 - e2;
		coef_a = e3 - e0 + (d12 <<< 1) + d12;
		coef_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
		coef_c = e2 - e0;
		coef_d = e1 <<< 1;
	end

	always_comb begin
		rsum = prod_q + HALF;
		rnd  = rsum[FRAC_BITS+W-1:FRAC_BITS];
		case (round_q)
			2'd0:    addend = b_q;
			2'd1:    addend = c_q;
			default: addend = d_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IS_IDLE;
			round_q <= 2'd0;
		end else begin
			unique case (state_q)
				IS_IDLE: begin
					if (start) begin
						state_q <= IS_COEF;
					end
				end
				IS_COEF: begin
					round_q <= 2'd0;
					state_q <= IS_MUL;
				end
				IS_MUL: state_q <= IS_ADD;
				IS_ADD: begin
					if (round_q == 2'd2) begin
						state_q <= IS_DONE;
					end else begin
						round_q <= round_q + 2'd1;
						state_q <= IS_MUL;
					end
				end
				IS_DONE: state_q <= IS_IDLE;
				default: state_q <= IS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IS_COEF) begin
			t_q <= coef_a;
			b_q <= coef_b;
			c_q <= coef_c;
			d_q <= coef_d;
		end
		if (state_q == IS_MUL) begin
			prod_q <= t_q * $signed({1'b0, x});
		end
		if (state_q == IS_ADD) begin
			t_q <= rnd + addend;
		end
	end

	// Halve with rounding toward +inf on ties, then clamp
	always_comb begin
		tp1    = t_q + W'(1);
		halved = tp1 >>> 1;
		if (halved > SMAX) begin
			result = SMAX[SAMPLE_BITS-1:0];
		end else if (halved < SMIN) begin
			result = SMIN[SAMPLE_BITS-1:0];
		end else begin
			result = halved[SAMPLE_BITS-1:0];
		end
	end

	assign done = (state_q == IS_DONE);

endmodule

// File: rtl/cubic_interpolating_resampler.sv
// ----------------------------------------------------------------------------
// cubic_interpolating_resampler: Catmull-Rom cubic sample rate converter
// Interleaved multichannel input, history in a synchronous RAM, fixed-point
// Q5.16 stream phase, saturated 24-bit interpolated output.
// ----------------------------------------------------------------------------
// A transaction that does not complete a frame leaves the block idle. A
// frame-completing transaction stalls the input until its F output frames,
// R results, are emitted: per result, history reads (one RAM read port, four
// taps), then the shared multiplier loop, then loading the output register.
// Reset: per-entry valid bits make unwritten history read as zero; phase,
// slot and registers reset.
// ----------------------------------------------------------------------------
module cubic_interpolating_resampler #(
	parameter int MAX_CHANNELS = cir_pkg::MAX_CHANNELS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input sample channel
	input  logic                                  src_valid,
	output logic                                  src_stall,
	input  cir_pkg::src_t                         src_data,
	// result channel
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output cir_pkg::res_t                         res_data,
	// APB configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [cir_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [cir_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [cir_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready
);
	import cir_pkg::*;

	localparam int DEPTH  = MAX_CHANNELS * HISTORY_FRAMES;
	localparam int AW     = $clog2(DEPTH);
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NW     = $clog2(MAX_CHANNELS + 1);
	localparam int CMP_W  = NCH_BITS + 1;
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int CW     = CNT_W + 1;

	localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << FRAC_BITS;
	localparam logic [STEP_BITS-1:0]  STEP_MIN  = STEP_BITS'(1) << (FRAC_BITS - 3);
	localparam logic [STEP_BITS-1:0]  STEP_RST  = STEP_BITS'(1) << FRAC_BITS;

	// Register indexes (byte address / 4)
	localparam logic REG_STEP = 1'b0;
	localparam logic REG_NCH  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FRAME = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CALC  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	// configuration
	logic [STEP_BITS-1:0] step_q;
	logic [NCH_BITS-1:0]  nch_q;

	// stream state
	logic [PHASE_BITS-1:0] phase_q;
	logic [1:0]            slot_q;     // slot holding the oldest frame

	// history entry written since reset, and its value for the pending read
	logic [DEPTH-1:0] hist_vld_q;
	logic             hist_rvld_q;

	// per-frame sequencing
	logic [CH_W-1:0]  ch_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       rd_cnt_q;
	logic             frame_last_q;
	sample_t          y_q [HISTORY_FRAMES];
	sample_t          val_q;

	// output register
	logic res_valid_q;
	res_t res_q;

	// derived
	logic                  cfg_wr;
	logic                  reg_sel;
	logic [NW-1:0]         nch_eff;
	logic [CMP_W-1:0]      nch_cmp;
	logic [STEP_BITS-1:0]  inc;
	logic [PHASE_BITS-1:0] phase_next;
	logic                  src_fire;
	logic                  in_use;
	logic                  completes;
	logic                  hist_we;
	logic                  last_ch;
	logic                  room;
	logic                  room_next;
	logic                  out_free;
	logic [1:0]            rd_slot;
	logic [AW-1:0]         waddr, raddr;
	sample_t               rdata;
	logic                  calc_start;
	logic                  calc_done;
	sample_t               calc_result;

	// ---------------------------------------------------------------------
	// Configuration port. Writes land on the access phase; pready is tied.
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_STEP: prdata = APB_DATA_BITS'(step_q);
			REG_NCH:  prdata = APB_DATA_BITS'(nch_q);
			default:  prdata = '0;
		endcase
	end

	// Channel count clamps to 1..MAX_CHANNELS; small steps clamp to 1/8,
	// which caps output frames per input frame at eight.
	always_comb begin
		if (nch_q == '0) begin
			nch_eff = NW'(1);
		end else if ({1'b0, nch_q} > CMP_W'(MAX_CHANNELS)) begin
			nch_eff = NW'(MAX_CHANNELS);
		end else begin
			nch_eff = NW'(nch_q);
		end
		nch_cmp = CMP_W'(nch_eff);
		inc     = (step_q < STEP_MIN) ? STEP_MIN : step_q;
		// phase < 1.0 whenever this is used, so the sum cannot wrap
		phase_next = phase_q + PHASE_BITS'(inc);
	end

	// ---------------------------------------------------------------------
	// Input side. Samples are taken only while idle; the history write
	// happens at the accept edge, so later reads never overlap it.
	// ---------------------------------------------------------------------
	assign src_stall = (state_q != ST_IDLE);
	assign src_fire  = src_valid && !src_stall;
	assign in_use    = CMP_W'(src_data.channel) < nch_cmp;
	assign completes = CMP_W'(src_data.channel) == (nch_cmp - CMP_W'(1));
	assign hist_we   = src_fire && in_use;

	assign waddr = AW'(32'(slot_q) * 32'(MAX_CHANNELS) + 32'(src_data.channel));

	// Taps are read oldest first: y0 at slot_q, the slot after the frame just written
	assign rd_slot = slot_q + rd_cnt_q[1:0];
	assign raddr   = AW'(32'(rd_slot) * 32'(MAX_CHANNELS) + 32'(ch_q));

	cir_hist_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (waddr),
		.wdata (src_data.sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------------------------------------------------------------
	// Interpolation unit, started as the last of the four taps is written into y_q
	// ---------------------------------------------------------------------
	assign calc_start = (state_q == ST_READ) && (rd_cnt_q == 3'd4);

	cir_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start),
		.y0     (y_q[0]),
		.y1     (y_q[1]),
		.y2     (y_q[2]),
		.y3     (y_q[3]),
		.x      (phase_q[FRAC_BITS-1:0]),
		.done   (calc_done),
		.result (calc_result)
	);

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	assign last_ch  = CMP_W'(ch_q) == (nch_cmp - CMP_W'(1));
	// Result budget: a whole output frame is emitted or none of it
	assign room      = (CW'(count_q) + CW'(nch_eff)) <= CW'(MAX_RESULTS);
	assign room_next = (CW'(count_q) + (CW'(nch_eff) << 1)) <= CW'(MAX_RESULTS);
	assign out_free  = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= STEP_RST;
			nch_q        <= NCH_BITS'(1);
			phase_q      <= '0;
			slot_q       <= '0;
			hist_vld_q   <= '0;
			hist_rvld_q  <= 1'b0;
			ch_q         <= '0;
			count_q      <= '0;
			rd_cnt_q     <= '0;
			frame_last_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (reg_sel)
					REG_STEP: step_q <= pwdata[STEP_BITS-1:0];
					REG_NCH:  nch_q  <= pwdata[NCH_BITS-1:0];
					default:  ;
				endcase
			end

			if (hist_we) begin
				hist_vld_q[waddr] <= 1'b1;
			end
			// trails the RAM address like the read data
			hist_rvld_q <= hist_vld_q[raddr];

			if (state_q == ST_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					// a sample of the highest channel in use completes the frame
					if (src_fire && in_use && completes) begin
						slot_q  <= slot_q + 2'd1;
						count_q <= '0;
						state_q <= ST_FRAME;
					end
				end
				ST_FRAME: begin
					if (phase_q >= PHASE_ONE) begin
						phase_q <= phase_q - PHASE_ONE;
						state_q <= ST_IDLE;
					end else if (room) begin
						ch_q         <= '0;
						rd_cnt_q     <= '0;
						// this output frame is the last if the next one won't run
						frame_last_q <= (phase_next >= PHASE_ONE) || !room_next;
						state_q      <= ST_READ;
					end else begin
						phase_q <= phase_next;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						count_q <= count_q + CNT_W'(1);
						if (last_ch) begin
							phase_q <= phase_next;
							state_q <= ST_FRAME;
						end else begin
							ch_q     <= ch_q + CH_W'(1);
							rd_cnt_q <= '0;
							state_q  <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Tap capture: RAM data arrives in the cycle after its address is issued
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && rd_cnt_q != 3'd0) begin
			y_q[2'(rd_cnt_q - 3'd1)] <= hist_rvld_q ? rdata : '0;
		end
		if (state_q == ST_CALC && calc_done) begin
			val_q <= calc_result;
		end
		if (state_q == ST_EMIT && out_free) begin
			res_q.out_sample  <= val_q;
			res_q.out_channel <= CHAN_BITS'(ch_q);
			res_q.last        <= last_ch && frame_last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
